// ===== rtl/vn2_pkg.sv =====
// ----------------------------------------------------------------------------
// vn2_pkg
// Shared types and constants of the 2D value noise block: lattice hash
// constants, corner offsets, word widths and the queued work word.
// ----------------------------------------------------------------------------
`default_nettype none

package vn2_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int MID_DEPTH_DEF = 4;
   localparam int OUT_DEPTH_DEF = 16;

   localparam int COORD_BITS = 32;
   localparam int WGT_BITS   = 16;
   localparam int VAL_BITS   = 18;
   localparam int DIFF_BITS  = VAL_BITS + 1;
   localparam int PROD_BITS  = 36;
   localparam int NUM_CORNERS = 4;

   localparam logic [31:0] HASH_MUL_Z    = 32'd57;
   localparam logic [31:0] HASH_MUL_SEED = 32'd131;
   localparam int          HASH_SHIFT    = 13;
   localparam logic [31:0] HASH_MUL_SQ   = 32'd15731;
   localparam logic [31:0] HASH_ADD_SQ   = 32'd789221;
   localparam logic [31:0] HASH_ADD_OUT  = 32'd1376312589;
   localparam logic [31:0] CORNER_BIAS   = 32'd1073741824;
   localparam int          CORNER_SHIFT  = 14;
   localparam logic [17:0] WGT_THREE     = 18'd196608;

   // corner order: (x,z), (x+1,z), (x,z+1), (x+1,z+1)
   localparam logic [31:0] CORNER_OFS [NUM_CORNERS] = '{32'd0, 32'd1, 32'd57, 32'd58};

   typedef struct packed {
      logic [COORD_BITS-1:0] xi;
      logic [COORD_BITS-1:0] zi;
      logic [WGT_BITS-1:0]   tx;
      logic [WGT_BITS-1:0]   tz;
   } lane_type;

endpackage

`default_nettype wire

// ===== rtl/vn2_fifo.sv =====
// ----------------------------------------------------------------------------
// vn2_fifo
// Small first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module vn2_fifo #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/vn2_front.sv =====
// ----------------------------------------------------------------------------
// vn2_front
// Input side: split each coordinate into lattice index and 16-bit fraction
// and hand the word to the work queue.
// ----------------------------------------------------------------------------
`default_nettype none

module vn2_front #(
   parameter int FRAC_BITS = vn2_pkg::FRAC_BITS_DEF
) (
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic signed [31:0] req_sample_x,
   input  wire logic signed [31:0] req_sample_z,
   input  wire logic               q_full,
   output logic                    q_push,
   output vn2_pkg::lane_type       q_word
);

   localparam int WB = vn2_pkg::WGT_BITS;

   logic [WB-1:0] tx, tz;

   generate
      if (FRAC_BITS >= WB) begin : g_trunc
         assign tx = req_sample_x[FRAC_BITS-1 -: WB];
         assign tz = req_sample_z[FRAC_BITS-1 -: WB];
      end else begin : g_widen
         assign tx = {req_sample_x[FRAC_BITS-1:0], {(WB-FRAC_BITS){1'b0}}};
         assign tz = {req_sample_z[FRAC_BITS-1:0], {(WB-FRAC_BITS){1'b0}}};
      end
   endgenerate

   assign req_full  = q_full;
   assign q_push    = req_push && !q_full;
   assign q_word.xi = 32'(req_sample_x >>> FRAC_BITS);
   assign q_word.zi = 32'(req_sample_z >>> FRAC_BITS);
   assign q_word.tx = tx;
   assign q_word.tz = tz;

endmodule

`default_nettype wire

// ===== rtl/vn2_back.sv =====
// ----------------------------------------------------------------------------
// vn2_back
// Execution side: ten-stage pipeline that hashes the four lattice corners,
// forms smoothstep weights and blends along x then z. Issue is credit
// limited so the result queue can never overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module vn2_back #(
   parameter int OUT_DEPTH = vn2_pkg::OUT_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [31:0]       seed,
   input  wire logic              q_empty,
   input  wire vn2_pkg::lane_type q_word,
   output logic                   q_pop,
   input  wire logic              out_taken,
   output logic                   res_push,
   output logic [17:0]            res_value
);

   localparam int NC = vn2_pkg::NUM_CORNERS;
   localparam int WB = vn2_pkg::WGT_BITS;
   localparam int VB = vn2_pkg::VAL_BITS;
   localparam int DB = vn2_pkg::DIFF_BITS;
   localparam int PB = vn2_pkg::PROD_BITS;
   localparam int CW = $clog2(OUT_DEPTH + 1);

   logic [CW-1:0] credit_ff, credit_in;
   logic [9:0]    vld_ff, vld_in;

   // stage 1
   logic [31:0]   base1_ff, base1_in;
   logic [31:0]   ttx1_ff, ttx1_in, ttz1_ff, ttz1_in;
   logic [17:0]   kx1_ff, kx1_in, kz1_ff, kz1_in;
   // stage 2..6 corner pipeline
   logic [31:0]   h2_ff [NC], h2_in [NC];
   logic [31:0]   h3_ff [NC], sq3_ff [NC], sq3_in [NC];
   logic [31:0]   h4_ff [NC], p4_ff [NC], p4_in [NC];
   logic [31:0]   m5_ff [NC], m5_in [NC];
   logic [VB-1:0] cv6_ff [NC], cv6_in [NC];
   // weights, carried along
   logic [WB-1:0] sx_ff [2:6], sz_ff [2:8];
   logic [WB-1:0] sx2_in, sz2_in;
   logic [49:0]   wprod_x, wprod_z;
   // blend
   logic signed [PB-1:0] px7_ff [2], px7_in [2];
   logic [VB-1:0]        a7_ff [2];
   logic [VB-1:0]        i8_ff [2], i8_in [2];
   logic signed [PB-1:0] p9_ff, p9_in;
   logic [VB-1:0]        a9_ff;
   logic [VB-1:0]        r10_ff, r10_in;

   logic [31:0]          h0 [NC];
   logic [31:0]          mm [NC];
   logic signed [31:0]   cbias [NC];
   logic signed [DB-1:0] dx [2];
   logic signed [DB-1:0] dz;

   assign q_pop = !q_empty && (credit_ff < CW'(OUT_DEPTH));
   assign vld_in = {vld_ff[8:0], q_pop};

   always_comb begin
      credit_in = credit_ff;
      if (q_pop && !out_taken) begin
         credit_in = credit_ff + 1'b1;
      end else if (out_taken && !q_pop) begin
         credit_in = credit_ff - 1'b1;
      end
   end

   always_comb begin
      base1_in = q_word.xi + q_word.zi * vn2_pkg::HASH_MUL_Z
               + seed * vn2_pkg::HASH_MUL_SEED;
      ttx1_in  = q_word.tx * q_word.tx;
      ttz1_in  = q_word.tz * q_word.tz;
      kx1_in   = vn2_pkg::WGT_THREE - {1'b0, q_word.tx, 1'b0};
      kz1_in   = vn2_pkg::WGT_THREE - {1'b0, q_word.tz, 1'b0};

      wprod_x  = ttx1_ff * kx1_ff;
      wprod_z  = ttz1_ff * kz1_ff;
      sx2_in   = wprod_x[47:32];
      sz2_in   = wprod_z[47:32];

      for (int c = 0; c < NC; c++) begin
         h0[c]     = base1_ff + vn2_pkg::CORNER_OFS[c];
         h2_in[c]  = (h0[c] << vn2_pkg::HASH_SHIFT) ^ h0[c];
         sq3_in[c] = h2_ff[c] * h2_ff[c];
         p4_in[c]  = sq3_ff[c] * vn2_pkg::HASH_MUL_SQ + vn2_pkg::HASH_ADD_SQ;
         m5_in[c]  = h4_ff[c] * p4_ff[c];
         mm[c]     = {1'b0, 31'(m5_ff[c] + vn2_pkg::HASH_ADD_OUT)};
         cbias[c]  = $signed(vn2_pkg::CORNER_BIAS - mm[c]);
         cv6_in[c] = cbias[c][31:vn2_pkg::CORNER_SHIFT];
      end

      for (int k = 0; k < 2; k++) begin
         dx[k]     = $signed({cv6_ff[2*k+1][VB-1], cv6_ff[2*k+1]})
                   - $signed({cv6_ff[2*k][VB-1], cv6_ff[2*k]});
         px7_in[k] = $signed({1'b0, sx_ff[6]}) * dx[k];
         i8_in[k]  = a7_ff[k] + px7_ff[k][VB+WB-1:WB];
      end

      dz     = $signed({i8_ff[1][VB-1], i8_ff[1]}) - $signed({i8_ff[0][VB-1], i8_ff[0]});
      p9_in  = $signed({1'b0, sz_ff[8]}) * dz;
      r10_in = a9_ff + p9_ff[VB+WB-1:WB];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
         vld_ff    <= '0;
      end else begin
         credit_ff <= credit_in;
         vld_ff    <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      base1_ff <= base1_in;
      ttx1_ff  <= ttx1_in;
      ttz1_ff  <= ttz1_in;
      kx1_ff   <= kx1_in;
      kz1_ff   <= kz1_in;
      sx_ff[2] <= sx2_in;
      sz_ff[2] <= sz2_in;
      for (int s = 3; s <= 6; s++) begin
         sx_ff[s] <= sx_ff[s-1];
      end
      for (int s = 3; s <= 8; s++) begin
         sz_ff[s] <= sz_ff[s-1];
      end
      for (int c = 0; c < NC; c++) begin
         h2_ff[c]  <= h2_in[c];
         h3_ff[c]  <= h2_ff[c];
         sq3_ff[c] <= sq3_in[c];
         h4_ff[c]  <= h3_ff[c];
         p4_ff[c]  <= p4_in[c];
         m5_ff[c]  <= m5_in[c];
         cv6_ff[c] <= cv6_in[c];
      end
      for (int k = 0; k < 2; k++) begin
         px7_ff[k] <= px7_in[k];
         a7_ff[k]  <= cv6_ff[2*k];
         i8_ff[k]  <= i8_in[k];
      end
      p9_ff  <= p9_in;
      a9_ff  <= i8_ff[0];
      r10_ff <= r10_in;
   end

   assign res_push  = vld_ff[9];
   assign res_value = r10_ff;

endmodule

`default_nettype wire

// ===== rtl/value_noise_2d_interpolated.sv =====
// Throughput: one sample per cycle, sustained while the result side keeps popping.
// Rate set by the ten-stage hash and blend pipeline, one issue a cycle, with a
// 16-entry result queue giving credit for every word in flight.
// Reset: both queues empty, pipeline drained, seed back to zero.
// ----------------------------------------------------------------------------
// value_noise_2d_interpolated
// 2D value noise: lattice hash of the four corners with a seed, blended with
// smoothstep weights along x then z; Q16.16 in, Q2.16 out.
// ----------------------------------------------------------------------------
`default_nettype none

module value_noise_2d_interpolated #(
   parameter int FRAC_BITS = vn2_pkg::FRAC_BITS_DEF,
   parameter int MID_DEPTH = vn2_pkg::MID_DEPTH_DEF,
   parameter int OUT_DEPTH = vn2_pkg::OUT_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic signed [31:0] req_sample_x,
   input  wire logic signed [31:0] req_sample_z,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic signed [17:0]      rsp_noise_value,
   input  wire logic               csr_wr_en,
   input  wire logic signed [31:0] csr_wr_data
);

   localparam int LW = $bits(vn2_pkg::lane_type);

   logic [31:0]       seed_ff, seed_in;
   logic              mq_push, mq_full, mq_empty, mq_pop;
   vn2_pkg::lane_type mq_wdata, mq_rdata;
   logic              res_push;
   logic [17:0]       res_value, out_data;
   logic              out_full, out_taken;

   assign seed_in = csr_wr_en ? csr_wr_data : seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   vn2_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .req_push     (req_push),
      .req_full     (req_full),
      .req_sample_x (req_sample_x),
      .req_sample_z (req_sample_z),
      .q_full       (mq_full),
      .q_push       (mq_push),
      .q_word       (mq_wdata)
   );

   vn2_fifo #(.WIDTH(LW), .DEPTH(MID_DEPTH)) u_mid_q (
      .clock     (clock),
      .reset     (reset),
      .push      (mq_push),
      .push_data (mq_wdata),
      .full      (mq_full),
      .pop       (mq_pop),
      .pop_data  (mq_rdata),
      .empty     (mq_empty)
   );

   vn2_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .seed      (seed_ff),
      .q_empty   (mq_empty),
      .q_word    (mq_rdata),
      .q_pop     (mq_pop),
      .out_taken (out_taken),
      .res_push  (res_push),
      .res_value (res_value)
   );

   assign out_taken = rsp_pop && !rsp_empty;

   vn2_fifo #(.WIDTH(18), .DEPTH(OUT_DEPTH)) u_out_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_value),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (out_data),
      .empty     (rsp_empty)
   );

   // credit issue keeps the result queue from filling past its depth
   assign rsp_noise_value = $signed(out_data) + $signed({17'd0, out_full & 1'b0});

endmodule

`default_nettype wire

// ===== rtl/vn2_check.sv =====
// ----------------------------------------------------------------------------
// vn2_check
// Port-level checks of the 2D value noise block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vn2_check (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_push,
   input wire logic               req_full,
   input wire logic               rsp_empty,
   input wire logic               rsp_pop,
   input wire logic signed [17:0] rsp_noise_value
);

   // leave reset with both sides open and nothing to deliver
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("block not clear after reset");

   // a waiting word holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_noise_value)))
      else $error("waiting result word changed or vanished");

   // blended value stays within the corner value span
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_noise_value >= -18'sd65536 && rsp_noise_value <= 18'sd65536))
      else $error("noise value out of range");

   // hold the result side empty while the first word crosses the pipeline
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> rsp_empty [*11])
      else $error("result word appeared without enough pipeline time");

endmodule

bind value_noise_2d_interpolated vn2_check u_vn2_check (
   .clock           (clock),
   .reset           (reset),
   .req_push        (req_push),
   .req_full        (req_full),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_noise_value (rsp_noise_value)
);

`default_nettype wire
